FILE: rtl/ppsc_pkg.sv
// Package: constants, codes and types of the pump controller.
package ppsc_pkg;

	localparam int DUTY_W        = 15;
	localparam int TIME_W        = 16;
	localparam int STEP_W        = 10;
	localparam int CODE_W        = 8;
	localparam int LEN_W         = 8;
	localparam int REQ_W         = 17;
	localparam int MODE_W        = 2;
	localparam int LEVEL_W       = 10;
	localparam int SINE_W        = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam int PWM_MAX_DEF      = 1023;
	localparam int SINE_ENTRIES_DEF = 256;

	localparam logic [DUTY_W-1:0] FULL_DUTY = 15'd25600;
	localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

	localparam logic [MODE_W-1:0] MODE_STOPPED  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SOFT     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RUNNING  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_FAILSAFE = 2'd3;

	localparam logic [CODE_W-1:0] CMD_STOP     = 8'd0;
	localparam logic [CODE_W-1:0] CMD_SET_DUTY = 8'd1;
	localparam logic [CODE_W-1:0] CMD_STATUS   = 8'd40;
	localparam logic [CODE_W-1:0] CMD_FAILSAFE = 8'hFF;
	localparam logic [LEN_W-1:0]  SET_DUTY_LEN = 8'd5;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_TIME = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 2'd3;

	localparam logic [DUTY_W-1:0] MIN_DUTY_RST  = 15'd7680;
	localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = 15'd24320;
	localparam logic [TIME_W-1:0] RAMP_TIME_RST = 16'd3000;
	localparam logic [STEP_W-1:0] RAMP_STEP_RST = 10'd20;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/ppsc_ifs.sv
// Interfaces: request, result and register write channels of the pump controller.
interface ppsc_item_if;
	import ppsc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [CODE_W-1:0]        cmd_code;
	logic [LEN_W-1:0]         cmd_length;
	logic signed [REQ_W-1:0]  duty_request;
	modport source (output valid, kind, cmd_code, cmd_length, duty_request, input ready);
	modport sink   (input valid, kind, cmd_code, cmd_length, duty_request, output ready);
endinterface

interface ppsc_result_if;
	import ppsc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 ack_valid;
	logic                 ack_status;
	logic [MODE_W-1:0]    mode;
	logic [LEVEL_W-1:0]   pwm_level;
	logic                 pump_on;
	logic [DUTY_W-1:0]    duty_now;
	modport source (output valid, ack_valid, ack_status, mode, pwm_level, pump_on, duty_now,
		input ready);
	modport sink   (input valid, ack_valid, ack_status, mode, pwm_level, pump_on, duty_now,
		output ready);
endinterface

interface ppsc_cfg_if;
	import ppsc_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ppsc_div.sv
// Shared restoring divider, one quotient bit per cycle.
module ppsc_div #(
	parameter int NUM_W = 29,
	parameter int DEN_W = 16,
	parameter int QUO_W = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic [NUM_W-1:0]        num,
	input  logic [DEN_W-1:0]        den,
	output ppsc_pkg::div_stat_t     stat,
	output logic [QUO_W-1:0]        quo
);
	import ppsc_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// numerator < den * 2^QUO_W, so the remainder always fits DEN_W bits
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= DEN_W'(num >> QUO_W);
			quo_q <= num[QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

FILE: rtl/pwm_pump_soft_start_controller.sv
// Top level: pump drive controller with quarter-sine soft start.
//
//   channel  dir  payload                                         accepted when
//   item     in   kind, cmd_code, cmd_length, duty_request        valid && ready
//   result   out  ack_valid, ack_status, mode, pwm_level,
//                 pump_on, duty_now                               valid && ready
//   cfg      in   index (register), data                          valid && ready
//
// One request at a time; item.ready is high only while the sequencer idles.
// Commands, and ticks that start no ramp step, go from accept straight to the result load.
// A ramp step runs one divide for the sine index, a sine table read, one
// multiply and one divide for the PWM level on the shared divider (10 quotient
// bits at default parameters); the last step takes the target and only divides.
// A result waits in the output register; a stalled result side holds the
// sequencer in its last state. cfg is always ready, no reset sweep needed.
module pwm_pump_soft_start_controller #(
	parameter int PWM_MAX      = ppsc_pkg::PWM_MAX_DEF,
	parameter int SINE_ENTRIES = ppsc_pkg::SINE_ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ppsc_item_if.sink      item,
	ppsc_result_if.source  result,
	ppsc_cfg_if.sink       cfg
);
	import ppsc_pkg::*;

	localparam int IDX_W  = $clog2(SINE_ENTRIES);
	localparam int PW     = $clog2(PWM_MAX + 1);
	localparam int QUO_W  = (IDX_W > PW) ? IDX_W : PW;
	localparam int NUM_A  = TIME_W + $clog2(SINE_ENTRIES + 1);
	localparam int NUM_B  = DUTY_W + PW;
	localparam int NUM_W  = (NUM_A > NUM_B) ? NUM_A : NUM_B;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_IDX,
		ST_MUL,
		ST_PWM,
		ST_PWM_WAIT,
		ST_DONE
	} state_t;

	// config registers
	logic [DUTY_W-1:0] min_duty_q, max_duty_q;
	logic [TIME_W-1:0] ramp_time_q;
	logic [STEP_W-1:0] ramp_step_q;

	// controller state
	state_t            st_q;
	logic [MODE_W-1:0] mode_q;
	logic [DUTY_W-1:0] target_q, current_q;
	logic [PW-1:0]     pwm_q;
	logic [TIME_W-1:0] elapsed_q, since_q;
	logic              active_q;
	logic              ack_q, err_q;
	logic [SINE_W-1:0] sine_q;

	// shared divider hookup
	logic              div_go_q;
	logic [NUM_W-1:0]  div_num_q;
	logic [TIME_W-1:0] div_den_q;
	div_stat_t         div_stat;
	logic [QUO_W-1:0]  div_quo;

	// result register
	logic               out_valid_q;
	logic               out_ack_q, out_err_q, out_on_q;
	logic [MODE_W-1:0]  out_mode_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic [DUTY_W-1:0]  out_duty_q;

	// quarter-sine table, folded to constants at elaboration:
	// odd Taylor terms to x^13 in Q30, truncated products, rounded to Q16, capped
	logic [SINE_W-1:0] sine_rom [SINE_ENTRIES];
	for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
		localparam logic [63:0] SX  = (64'(g) * HALF_PI_Q30) / 64'(SINE_ENTRIES);
		localparam logic [63:0] T1  = ((((SX * SX) >> 30) * SX) >> 30) / 64'd6;
		localparam logic [63:0] T2  = ((((T1 * SX) >> 30) * SX) >> 30) / 64'd20;
		localparam logic [63:0] T3  = ((((T2 * SX) >> 30) * SX) >> 30) / 64'd42;
		localparam logic [63:0] T4  = ((((T3 * SX) >> 30) * SX) >> 30) / 64'd72;
		localparam logic [63:0] T5  = ((((T4 * SX) >> 30) * SX) >> 30) / 64'd110;
		localparam logic [63:0] T6  = ((((T5 * SX) >> 30) * SX) >> 30) / 64'd156;
		localparam logic [63:0] SUM = SX - T1 + T2 - T3 + T4 - T5 + T6;
		localparam logic [63:0] RND = (SUM + 64'd8192) >> 14;
		assign sine_rom[g] = (RND > 64'd65535) ? '1 : RND[SINE_W-1:0];
	end

	ppsc_div #(
		.NUM_W (NUM_W),
		.DEN_W (TIME_W),
		.QUO_W (QUO_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	logic              accept;
	logic              res_take;
	logic              load_out;
	logic [TIME_W-1:0] elapsed_n, since_n;
	logic              req_bad;
	logic [DUTY_W-1:0] clamp_lo, clamp_duty;
	logic [DUTY_W-1:0] duty_sat;

	assign accept   = item.valid && item.ready;
	assign res_take = result.valid && result.ready;
	// result register takes a new status when empty or being drained
	assign load_out = (st_q == ST_DONE) && (!out_valid_q || result.ready);

	// saturating tick counters
	assign elapsed_n = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign since_n   = (since_q == '1) ? since_q : since_q + 1'b1;

	// set-duty checks: short frame, negative, above full scale
	assign req_bad = (item.cmd_length < SET_DUTY_LEN) || item.duty_request[REQ_W-1]
		|| (item.duty_request[REQ_W-2:0] > (REQ_W-1)'(FULL_DUTY));
	// max clamp last, it wins over min
	assign clamp_lo   = (item.duty_request[DUTY_W-1:0] < min_duty_q) ?
		min_duty_q : item.duty_request[DUTY_W-1:0];
	assign clamp_duty = (clamp_lo > max_duty_q) ? max_duty_q : clamp_lo;

	assign duty_sat = (current_q > FULL_DUTY) ? FULL_DUTY : current_q;

	assign item.ready = (st_q == ST_IDLE);
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_duty_q  <= MIN_DUTY_RST;
			max_duty_q  <= MAX_DUTY_RST;
			ramp_time_q <= RAMP_TIME_RST;
			ramp_step_q <= RAMP_STEP_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MIN_DUTY:  min_duty_q  <= cfg.data[DUTY_W-1:0];
				REG_MAX_DUTY:  max_duty_q  <= cfg.data[DUTY_W-1:0];
				REG_RAMP_TIME: ramp_time_q <= cfg.data[TIME_W-1:0];
				REG_RAMP_STEP: ramp_step_q <= cfg.data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer with its registered state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			mode_q      <= MODE_STOPPED;
			target_q    <= '0;
			current_q   <= '0;
			pwm_q       <= '0;
			elapsed_q   <= '0;
			since_q     <= '0;
			active_q    <= 1'b0;
			ack_q       <= 1'b0;
			err_q       <= 1'b0;
			sine_q      <= '0;
			div_go_q    <= 1'b0;
			div_num_q   <= '0;
			div_den_q   <= '0;
			out_valid_q <= 1'b0;
			out_ack_q   <= 1'b0;
			out_err_q   <= 1'b0;
			out_mode_q  <= MODE_STOPPED;
			out_level_q <= '0;
			out_on_q    <= 1'b0;
			out_duty_q  <= '0;
		end else begin
			div_go_q <= 1'b0;
			if (res_take && !load_out)
				out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						ack_q <= 1'b0;
						err_q <= 1'b0;
						st_q  <= ST_DONE;
						if (!item.kind) begin
							if (mode_q == MODE_SOFT) begin
								elapsed_q <= elapsed_n;
								since_q   <= since_n;
								if (since_n >= TIME_W'(ramp_step_q)) begin
									since_q <= '0;
									if (elapsed_n >= ramp_time_q) begin
										current_q <= target_q;
										mode_q    <= MODE_RUNNING;
										st_q      <= ST_PWM;
									end else begin
										// sine index = elapsed * entries / ramp_time
										div_num_q <= NUM_W'(elapsed_n) * NUM_W'(SINE_ENTRIES);
										div_den_q <= ramp_time_q;
										div_go_q  <= 1'b1;
										st_q      <= ST_IDX;
									end
								end
							end
						end else if (item.cmd_length != '0) begin
							ack_q <= 1'b1;
							case (item.cmd_code)
								CMD_STOP, CMD_FAILSAFE: begin
									pwm_q     <= '0;
									current_q <= '0;
									target_q  <= '0;
									active_q  <= 1'b0;
									mode_q    <= (item.cmd_code == CMD_FAILSAFE) ?
										MODE_FAILSAFE : MODE_STOPPED;
								end
								CMD_SET_DUTY: begin
									if (req_bad) begin
										err_q <= 1'b1;
									end else if (item.duty_request == '0) begin
										pwm_q     <= '0;
										current_q <= '0;
										target_q  <= '0;
										active_q  <= 1'b0;
										mode_q    <= MODE_STOPPED;
									end else begin
										target_q  <= clamp_duty;
										elapsed_q <= '0;
										since_q   <= '0;
										current_q <= '0;
										pwm_q     <= '0;
										active_q  <= 1'b1;
										mode_q    <= MODE_SOFT;
									end
								end
								CMD_STATUS: ;
								default: err_q <= 1'b1;
							endcase
						end
					end
				end
				ST_IDX: begin
					if (div_stat.done) begin
						sine_q <= sine_rom[div_quo[IDX_W-1:0]];
						st_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					current_q <= DUTY_W'((32'(target_q) * 32'(sine_q)) >> SINE_W);
					st_q      <= ST_PWM;
				end
				ST_PWM: begin
					// level = min(duty, full) * PWM_MAX / full
					div_num_q <= NUM_W'(duty_sat) * NUM_W'(PWM_MAX);
					div_den_q <= TIME_W'(FULL_DUTY);
					div_go_q  <= 1'b1;
					st_q      <= ST_PWM_WAIT;
				end
				ST_PWM_WAIT: begin
					if (div_stat.done) begin
						pwm_q <= div_quo[PW-1:0];
						st_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						out_ack_q   <= ack_q;
						out_err_q   <= err_q;
						out_mode_q  <= mode_q;
						out_level_q <= LEVEL_W'(pwm_q);
						out_on_q    <= active_q;
						out_duty_q  <= current_q;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid      = out_valid_q;
	assign result.ack_valid  = out_ack_q;
	assign result.ack_status = out_err_q;
	assign result.mode       = out_mode_q;
	assign result.pwm_level  = out_level_q;
	assign result.pump_on    = out_on_q;
	assign result.duty_now   = out_duty_q;

`ifndef SYNTHESIS
	a_active_mode: assert property (@(posedge clk) disable iff (!arst_n)
		active_q == ((mode_q == MODE_SOFT) || (mode_q == MODE_RUNNING)))
		else $error("pump flag disagrees with mode");
	a_ramp_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_SOFT) |-> (current_q <= target_q))
		else $error("ramp duty above target");
	a_pwm_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pwm_q) <= 32'(PWM_MAX))
		else $error("pwm level above maximum");
	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_IDX || st_q == ST_PWM_WAIT) && !div_go_q) |->
		(div_stat.busy || div_stat.done))
		else $error("waiting on an idle divider");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == ST_DONE))
		else $error("result loaded outside done state");
`endif

endmodule
